// ----- sv/gk15_pkg.sv -----
// ----------------------------------------------------------------------------
// gk15_pkg
// Shared types, constants and weight tables of the 15-point Gauss-Kronrod rule.
// ----------------------------------------------------------------------------
package gk15_pkg;

  localparam int SAMPLE_FRACTION_BITS = 16;
  localparam int WEIGHT_FRACTION_BITS = 24;

  localparam int          W_SH   = 32 - WEIGHT_FRACTION_BITS;
  localparam logic [32:0] W_HALF = (W_SH == 0) ? 33'd0 : (33'd1 << (W_SH - 1));

  localparam logic [63:0] CAP47  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] BIGCAP = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [3:0]         sample_slot;
    logic signed [31:0] interval_start;
    logic signed [31:0] interval_end;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] integral;
    logic [46:0]        error_estimate;
  } out_word_t;

  typedef enum logic [2:0] {
    MA_SAMPLE, MA_KACC, MA_DIFF, MA_DEV, MA_RSUM, MA_XQ, MA_RESASC
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_KRON, MB_GAUSS, MB_LEN, MB_DEV_W, MB_ROOT, MB_P
  } mul_b_e;

  typedef enum logic [1:0] {
    ERR_ABS, ERR_RES, ERR_PROD
  } err_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    logic     mul_hi;
    mul_a_e   a_sel;
    mul_b_e   b_sel;
    logic     kacc_add;
    logic     gacc_add;
    logic     int_cap;
    logic     abs_cap;
    logic     rsum_clr;
    logic     rsum_add;
    logic     res_cap;
    logic     div_init;
    logic     div_step;
    logic     sq_init;
    logic     sq_step;
    logic     p_cap;
    logic     err_load;
    err_sel_e err_sel;
    logic     out_load;
    logic     acc_clr;
    logic [3:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic res_zero;
    logic res_ge;
  } dp_status_t;

  // Kronrod weights in Q0.32 by slot
  function automatic logic [31:0] kron_w32(input logic [3:0] slot);
    logic [31:0] w;
    case (slot)
      4'd0:          w = 32'd899718945;
      4'd1, 4'd8:    w = 32'd98506458;
      4'd2, 4'd9:    w = 32'd270978474;
      4'd3, 4'd10:   w = 32'd450069667;
      4'd4, 4'd11:   w = 32'd604101151;
      4'd5, 4'd12:   w = 32'd725869774;
      4'd6, 4'd13:   w = 32'd817549508;
      4'd7, 4'd14:   w = 32'd878032792;
      default:       w = 32'd0;
    endcase
    return w;
  endfunction

  // Gauss weights in Q0.32 by slot, zero on Kronrod-only points
  function automatic logic [31:0] gauss_w32(input logic [3:0] slot);
    logic [31:0] w;
    case (slot)
      4'd0:        w = 32'd1795121025;
      4'd2, 4'd9:  w = 32'd556133695;
      4'd4, 4'd11: w = 32'd1201325509;
      4'd6, 4'd13: w = 32'd1639947580;
      default:     w = 32'd0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] weight_round(input logic [31:0] w32);
    logic [32:0] t;
    t = {1'b0, w32} + W_HALF;
    return 32'(t >> W_SH);
  endfunction

endpackage

// ----- sv/gk15_if.sv -----
// ----------------------------------------------------------------------------
// gk15 stream interfaces
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface gk15_in_if;
  logic               valid;
  logic               ready;
  gk15_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gk15_out_if;
  logic                valid;
  logic                ready;
  gk15_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/gk15_dp.sv -----
// ----------------------------------------------------------------------------
// gk15_dp
// Datapath: sample store, accumulators, shared 32x32 multiplier, divider and
// square-root steps, result registers.
// ----------------------------------------------------------------------------
module gk15_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gk15_pkg::in_word_t   in_word_i,
  input  gk15_pkg::dp_cmd_t    cmd_i,
  output gk15_pkg::dp_status_t status_o,
  output gk15_pkg::out_word_t  out_word_o
);

  localparam logic signed [49:0] MAX48 = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] MIN48 = -MAX48 - 50'sd1;

  function automatic logic [63:0] rnd(input logic [95:0] p, input int sh,
                                      input logic [63:0] cap);
    logic [96:0] t;
    logic [96:0] r;
    t = {1'b0, p} + (97'd1 << (sh - 1));
    r = t >> sh;
    if (r > {33'd0, cap}) return cap;
    return r[63:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > MAX48) return MAX48[47:0];
    if (v < MIN48) return MIN48[47:0];
    return v[47:0];
  endfunction

  logic signed [31:0] store [15];
  logic signed [31:0] rd_q;
  logic signed [31:0] s_q;
  logic [3:0]         slot_q;
  logic               len_neg_q;
  logic [31:0]        lenmag_q;
  logic signed [47:0] kacc_q, gacc_q;
  logic [95:0]        prod_q, prod_d;
  logic signed [47:0] int_q;
  logic [46:0]        abs_q, res_q, err_q;
  logic [63:0]        rsum_q;
  logic [47:0]        num_q;
  logic [31:0]        xq_q, root_q, p_q;
  logic [63:0]        sv_q;
  logic [33:0]        rem_q;
  gk15_pkg::out_word_t out_q;

  logic signed [32:0] len;
  logic [31:0]        s_abs;
  logic [47:0]        kacc_abs;
  logic signed [48:0] diff;
  logic [48:0]        diff_abs;
  logic signed [49:0] dev;
  logic [49:0]        dev_abs;
  logic [63:0]        a_full;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        r_w;
  logic signed [49:0] addend;
  logic [63:0]        imag;
  logic [54:0]        num55;
  logic [47:0]        n2;
  logic               div_ge;
  logic [35:0]        r2, trial;
  logic               sq_ge;
  logic [46:0]        err_d;

  assign len      = 33'(in_word_i.interval_end) - 33'(in_word_i.interval_start);
  assign s_abs    = s_q[31] ? 32'(-s_q) : 32'(s_q);
  assign kacc_abs = kacc_q[47] ? 48'(-kacc_q) : 48'(kacc_q);
  assign diff     = 49'(kacc_q) - 49'(gacc_q);
  assign diff_abs = diff[48] ? 49'(-diff) : 49'(diff);
  assign dev      = (50'(rd_q) <<< 1) - 50'(kacc_q);
  assign dev_abs  = dev[49] ? 50'(-dev) : 50'(dev);

  always_comb begin
    case (cmd_i.a_sel)
      gk15_pkg::MA_SAMPLE: a_full = 64'(s_abs);
      gk15_pkg::MA_KACC:   a_full = 64'(kacc_abs);
      gk15_pkg::MA_DIFF:   a_full = 64'(diff_abs);
      gk15_pkg::MA_DEV:    a_full = 64'(dev_abs);
      gk15_pkg::MA_RSUM:   a_full = rsum_q;
      gk15_pkg::MA_XQ:     a_full = 64'(xq_q);
      gk15_pkg::MA_RESASC: a_full = 64'(res_q);
      default:             a_full = '0;
    endcase
    case (cmd_i.b_sel)
      gk15_pkg::MB_KRON:  mul_b = gk15_pkg::weight_round(gk15_pkg::kron_w32(slot_q));
      gk15_pkg::MB_GAUSS: mul_b = gk15_pkg::weight_round(gk15_pkg::gauss_w32(slot_q));
      gk15_pkg::MB_LEN:   mul_b = lenmag_q;
      gk15_pkg::MB_DEV_W: mul_b = gk15_pkg::weight_round(gk15_pkg::kron_w32(cmd_i.idx));
      gk15_pkg::MB_ROOT:  mul_b = root_q;
      gk15_pkg::MB_P:     mul_b = p_q;
      default:            mul_b = '0;
    endcase
  end

  assign mul_a  = cmd_i.mul_hi ? a_full[63:32] : a_full[31:0];
  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign prod_d = cmd_i.mul_hi ? prod_q + {mul_p, 32'd0} : {32'd0, mul_p};

  assign r_w    = rnd(prod_q, gk15_pkg::WEIGHT_FRACTION_BITS, gk15_pkg::BIGCAP);
  assign addend = s_q[31] ? -50'(r_w[47:0]) : 50'(r_w[47:0]);
  assign imag   = rnd(prod_q, gk15_pkg::SAMPLE_FRACTION_BITS + 1, gk15_pkg::CAP47);

  assign num55  = (55'(abs_q) << 7) + (55'(abs_q) << 6) + (55'(abs_q) << 3);
  assign status_o = {(res_q == '0) || (abs_q == '0), num55 >= 55'(res_q)};

  assign n2     = {num_q[46:0], 1'b0};
  assign div_ge = n2 >= {1'b0, res_q};
  assign r2     = {rem_q, sv_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = r2 >= trial;

  always_comb begin
    case (cmd_i.err_sel)
      gk15_pkg::ERR_ABS: err_d = abs_q;
      gk15_pkg::ERR_RES: err_d = res_q;
      default:           err_d = 47'(rnd(prod_q, 32, gk15_pkg::CAP47));
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item && (in_word_i.sample_slot != 4'd15)) begin
      store[in_word_i.sample_slot] <= in_word_i.sample_value;
    end
    if (cmd_i.idx != 4'd15) rd_q <= store[cmd_i.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kacc_q <= '0;
      gacc_q <= '0;
    end else if (cmd_i.acc_clr) begin
      kacc_q <= '0;
      gacc_q <= '0;
    end else begin
      if (cmd_i.kacc_add) kacc_q <= sat48(50'(kacc_q) + addend);
      if (cmd_i.gacc_add) gacc_q <= sat48(50'(gacc_q) + addend);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      s_q       <= in_word_i.sample_value;
      slot_q    <= in_word_i.sample_slot;
      len_neg_q <= len[32];
      lenmag_q  <= len[32] ? 32'(-len) : 32'(len);
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.int_cap) begin
      int_q <= (kacc_q[47] != len_neg_q) ? -48'(imag) : 48'(imag);
    end
    if (cmd_i.abs_cap) abs_q <= imag[46:0];
    if (cmd_i.rsum_clr) rsum_q <= '0;
    else if (cmd_i.rsum_add) rsum_q <= rsum_q + rnd(prod_q,
        gk15_pkg::WEIGHT_FRACTION_BITS + 1, gk15_pkg::BIGCAP);
    if (cmd_i.res_cap) res_q <= imag[46:0];
    if (cmd_i.div_init) begin
      num_q <= num55[47:0];
      xq_q  <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= div_ge ? n2 - {1'b0, res_q} : n2;
      xq_q  <= {xq_q[30:0], div_ge};
    end
    if (cmd_i.sq_init) begin
      sv_q   <= {xq_q, 32'd0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_step) begin
      sv_q   <= {sv_q[61:0], 2'b00};
      rem_q  <= sq_ge ? 34'(r2 - trial) : 34'(r2);
      root_q <= {root_q[30:0], sq_ge};
    end
    if (cmd_i.p_cap) p_q <= prod_q[63:32];
    if (cmd_i.err_load) err_q <= err_d;
    if (cmd_i.out_load) begin
      out_q.integral       <= int_q;
      out_q.error_estimate <= err_q;
    end
  end

  assign out_word_o = out_q;

endmodule

// ----- sv/gk15_ctrl.sv -----
// ----------------------------------------------------------------------------
// gk15_ctrl
// Sequencer: per-sample accumulation, then the end-of-interval pass over the
// store and, unless the error ratio is zero or saturates, its division, square root and final scaling.
// ----------------------------------------------------------------------------
module gk15_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gk15_pkg::dp_status_t status_i,
  output gk15_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [25:0] {
    S_IDLE   = 26'd1 << 0,  S_KMUL  = 26'd1 << 1,  S_GMUL = 26'd1 << 2,
    S_GACC   = 26'd1 << 3,  S_IMLO  = 26'd1 << 4,  S_IMHI = 26'd1 << 5,
    S_IFIN   = 26'd1 << 6,  S_EMLO  = 26'd1 << 7,  S_EMHI = 26'd1 << 8,
    S_EFIN   = 26'd1 << 9,  S_RMLO  = 26'd1 << 10, S_RMHI = 26'd1 << 11,
    S_RACC   = 26'd1 << 12, S_AMLO  = 26'd1 << 13, S_AMHI = 26'd1 << 14,
    S_AFIN   = 26'd1 << 15, S_DEC   = 26'd1 << 16, S_DIV  = 26'd1 << 17,
    S_SQINIT = 26'd1 << 18, S_SQRT  = 26'd1 << 19, S_PMUL = 26'd1 << 20,
    S_PFIN   = 26'd1 << 21, S_XMLO  = 26'd1 << 22, S_XMHI = 26'd1 << 23,
    S_XFIN   = 26'd1 << 24, S_DONE  = 26'd1 << 25
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q[3:0];
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          last_d          = last_i;
          state_d         = S_KMUL;
        end
      end
      S_KMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = gk15_pkg::MA_SAMPLE;
        cmd_o.b_sel  = gk15_pkg::MB_KRON;
        state_d      = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.kacc_add = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.a_sel    = gk15_pkg::MA_SAMPLE;
        cmd_o.b_sel    = gk15_pkg::MB_GAUSS;
        state_d        = S_GACC;
      end
      S_GACC: begin
        cmd_o.gacc_add = 1'b1;
        state_d        = last_q ? S_IMLO : S_IDLE;
      end
      S_IMLO, S_IMHI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = (state_q == S_IMHI);
        cmd_o.a_sel  = gk15_pkg::MA_KACC;
        cmd_o.b_sel  = gk15_pkg::MB_LEN;
        state_d      = (state_q == S_IMLO) ? S_IMHI : S_IFIN;
      end
      S_IFIN: begin
        cmd_o.int_cap = 1'b1;
        state_d       = S_EMLO;
      end
      S_EMLO, S_EMHI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = (state_q == S_EMHI);
        cmd_o.a_sel  = gk15_pkg::MA_DIFF;
        cmd_o.b_sel  = gk15_pkg::MB_LEN;
        state_d      = (state_q == S_EMLO) ? S_EMHI : S_EFIN;
      end
      S_EFIN: begin
        cmd_o.abs_cap  = 1'b1;
        cmd_o.rsum_clr = 1'b1;
        cmd_o.idx      = 4'd0;
        cnt_d          = '0;
        state_d        = S_RMLO;
      end
      S_RMLO, S_RMHI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = (state_q == S_RMHI);
        cmd_o.a_sel  = gk15_pkg::MA_DEV;
        cmd_o.b_sel  = gk15_pkg::MB_DEV_W;
        state_d      = (state_q == S_RMLO) ? S_RMHI : S_RACC;
      end
      S_RACC: begin
        cmd_o.rsum_add = 1'b1;
        if (cnt_q == 5'd14) begin
          state_d = S_AMLO;
        end else begin
          cmd_o.idx = 4'(cnt_q + 5'd1);
          cnt_d     = cnt_q + 5'd1;
          state_d   = S_RMLO;
        end
      end
      S_AMLO, S_AMHI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = (state_q == S_AMHI);
        cmd_o.a_sel  = gk15_pkg::MA_RSUM;
        cmd_o.b_sel  = gk15_pkg::MB_LEN;
        state_d      = (state_q == S_AMLO) ? S_AMHI : S_AFIN;
      end
      S_AFIN: begin
        cmd_o.res_cap = 1'b1;
        state_d       = S_DEC;
      end
      S_DEC: begin
        if (status_i.res_zero) begin
          cmd_o.err_load = 1'b1;
          cmd_o.err_sel  = gk15_pkg::ERR_ABS;
          state_d        = S_DONE;
        end else if (status_i.res_ge) begin
          cmd_o.err_load = 1'b1;
          cmd_o.err_sel  = gk15_pkg::ERR_RES;
          state_d        = S_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = S_SQINIT;
      end
      S_SQINIT: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = gk15_pkg::MA_XQ;
        cmd_o.b_sel  = gk15_pkg::MB_ROOT;
        state_d      = S_PFIN;
      end
      S_PFIN: begin
        cmd_o.p_cap = 1'b1;
        state_d     = S_XMLO;
      end
      S_XMLO, S_XMHI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = (state_q == S_XMHI);
        cmd_o.a_sel  = gk15_pkg::MA_RESASC;
        cmd_o.b_sel  = gk15_pkg::MB_P;
        state_d      = (state_q == S_XMLO) ? S_XMHI : S_XFIN;
      end
      S_XFIN: begin
        cmd_o.err_load = 1'b1;
        cmd_o.err_sel  = gk15_pkg::ERR_PROD;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/gauss_kronrod_15_rule_top.sv -----
// Each sample word is accepted, then takes three multiply/add steps on the single
//   shared 32x32 multiplier; the next word is taken after that.
// The result of the last word follows the 15-slot pass and, unless the error ratio
//   saturates or is zero, the 32-step divide and root and the final scaling.
// Reset clears the sequencer, the Kronrod and Gauss accumulators and the output valid; the sample
//   store is not cleared.
// ----------------------------------------------------------------------------
// gauss_kronrod_15_rule_top
// 15-point Gauss-Kronrod quadrature of one interval with QUADPACK error.
// ----------------------------------------------------------------------------
module gauss_kronrod_15_rule_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  gk15_in_if.sink    in_i,
  gk15_out_if.source out_o
);

  gk15_pkg::dp_cmd_t    cmd;
  gk15_pkg::dp_status_t status;

  gk15_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .last_i      (in_i.data.last_sample),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gk15_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_i.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_o.data)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a word is in progress");

  a_result_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load))
    else $error("result valid without a result load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");

endmodule
